// File: hw/rtl/nfsa_pkg.sv
package nfsa_pkg;

    // Pool size; slot IDs run 0 .. SLOTS-1, slot 0 is reserved.
    localparam int SLOTS  = 256;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Request codes
    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    // Result status codes
    typedef enum logic [1:0]
    {
        ST_DONE       = 2'd0,
        ST_FULL       = 2'd1,
        ST_NOT_IN_USE = 2'd2,
        ST_ZERO       = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [2:0]
    {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE_CHK,
        S_RESP
    } state_t;

endpackage

// File: hw/rtl/next_fit_slot_allocator.sv
// Next-fit slot allocator.
// Input channel (in_valid/in_ready): one word per request. op = allocate
// grants the next free slot searching circularly from the last granted slot,
// skipping slot 0; op = free releases slot_to_free.
// Output channel (out_valid/out_ready): exactly one result word per request:
// status, granted_slot and used_count after the request.
// The used flags live in a 1-bit x SLOTS memory with registered read. An
// allocate streams one slot address per cycle through that read port and
// checks each registered read result, until it finds a free slot or has tried
// every slot (pool full). A free reads the flag and then checks it; a free
// of slot 0 or of a slot outside the pool goes straight to the result.
// One request at a time: in_ready is high only while the sequencer is idle.
// The result sits in an output register; a new request is taken while it
// waits. If the receiver stalls, the next result holds in the sequencer
// until the output register empties.
// Reset: after rst_n releases, a clearing pass writes every flag to free,
// during which in_ready stays low.
module next_fit_slot_allocator
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       op,
    input  logic [7:0] slot_to_free,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [7:0] granted_slot,
    output logic [7:0] used_count
);

    localparam int TRY_W = nfsa_pkg::SLOT_W + 1;
    localparam logic [TRY_W-1:0] TRY_END = TRY_W'(nfsa_pkg::SLOTS);
    localparam logic [nfsa_pkg::SLOT_W-1:0] LAST_IDX = nfsa_pkg::SLOT_W'(nfsa_pkg::SLOTS - 1);

    // used-flag memory
    logic mem [nfsa_pkg::SLOTS];
    logic                        mem_we;
    logic [nfsa_pkg::SLOT_W-1:0] mem_waddr;
    logic                        mem_wdata;
    logic [nfsa_pkg::SLOT_W-1:0] mem_raddr;
    logic                        rd_data_reg;

    nfsa_pkg::state_t            state_reg, state_next;
    logic [TRY_W-1:0]            tries_reg, tries_next;
    logic                        chk_valid_reg, chk_valid_next;
    logic [nfsa_pkg::SLOT_W-1:0] chk_addr_reg, chk_addr_next;
    logic [nfsa_pkg::SLOT_W-1:0] last_reg, last_next;
    logic [nfsa_pkg::SLOT_W-1:0] count_reg, count_next;
    logic [nfsa_pkg::SLOT_W-1:0] clr_reg, clr_next;
    logic [nfsa_pkg::SLOT_W-1:0] slot_reg, slot_next;
    nfsa_pkg::status_t           res_status_reg, res_status_next;
    logic [nfsa_pkg::SLOT_W-1:0] res_slot_reg, res_slot_next;

    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  status_reg, status_next;
    logic [7:0]                  granted_reg, granted_next;
    logic [7:0]                  used_reg, used_next;

    logic                        in_fire;
    logic                        slot_oob;
    logic [nfsa_pkg::SLOT_W-1:0] scan_addr;

    assign in_ready     = (state_reg == nfsa_pkg::S_IDLE);
    assign in_fire      = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign granted_slot = granted_reg;
    assign used_count   = used_reg;

    // slot IDs at or past the pool end count as not in use
    assign slot_oob  = (32'(slot_to_free) >= 32'(nfsa_pkg::SLOTS));
    assign scan_addr = last_reg + tries_reg[nfsa_pkg::SLOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nfsa_pkg::S_CLEAR;
            tries_reg     <= '0;
            chk_valid_reg <= 1'b0;
            last_reg      <= '0;
            count_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tries_reg     <= tries_next;
            chk_valid_reg <= chk_valid_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        chk_addr_reg   <= chk_addr_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        status_reg     <= status_next;
        granted_reg    <= granted_next;
        used_reg       <= used_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        tries_next      = tries_reg;
        chk_valid_next  = 1'b0;
        chk_addr_next   = chk_addr_reg;
        last_next       = last_reg;
        count_next      = count_reg;
        clr_next        = clr_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        granted_next    = granted_reg;
        used_next       = used_reg;
        mem_we          = 1'b0;
        mem_waddr       = clr_reg;
        mem_wdata       = 1'b0;
        mem_raddr       = scan_addr;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            nfsa_pkg::S_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = nfsa_pkg::S_IDLE;
                end
            end

            nfsa_pkg::S_IDLE:
            begin
                // free: look up the flag right away
                mem_raddr = nfsa_pkg::SLOT_W'(slot_to_free);
                if (in_fire)
                begin
                    slot_next     = nfsa_pkg::SLOT_W'(slot_to_free);
                    res_slot_next = '0;
                    if (nfsa_pkg::op_t'(op) == nfsa_pkg::OP_ALLOC)
                    begin
                        tries_next = '0;
                        state_next = nfsa_pkg::S_SCAN;
                    end
                    else if (slot_to_free == 8'd0)
                    begin
                        res_status_next = nfsa_pkg::ST_ZERO;
                        state_next      = nfsa_pkg::S_RESP;
                    end
                    else if (slot_oob)
                    begin
                        res_status_next = nfsa_pkg::ST_NOT_IN_USE;
                        state_next      = nfsa_pkg::S_RESP;
                    end
                    else
                    begin
                        state_next = nfsa_pkg::S_FREE_CHK;
                    end
                end
            end

            nfsa_pkg::S_SCAN:
            begin
                // issue one address per cycle, check the previous one
                if (tries_reg != TRY_END)
                begin
                    tries_next     = tries_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_addr_next  = scan_addr;
                end
                if (chk_valid_reg && (chk_addr_reg != '0) && !rd_data_reg)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = chk_addr_reg;
                    mem_wdata       = 1'b1;
                    count_next      = count_reg + 1'b1;
                    last_next       = chk_addr_reg;
                    res_status_next = nfsa_pkg::ST_DONE;
                    res_slot_next   = chk_addr_reg;
                    chk_valid_next  = 1'b0;
                    state_next      = nfsa_pkg::S_RESP;
                end
                else if (!chk_valid_reg && (tries_reg == TRY_END))
                begin
                    res_status_next = nfsa_pkg::ST_FULL;
                    state_next      = nfsa_pkg::S_RESP;
                end
            end

            nfsa_pkg::S_FREE_CHK:
            begin
                if (rd_data_reg)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = slot_reg;
                    mem_wdata       = 1'b0;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    res_status_next = nfsa_pkg::ST_DONE;
                end
                else
                begin
                    res_status_next = nfsa_pkg::ST_NOT_IN_USE;
                end
                state_next = nfsa_pkg::S_RESP;
            end

            nfsa_pkg::S_RESP:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    granted_next   = 8'(res_slot_reg);
                    used_next      = 8'(count_reg);
                    state_next     = nfsa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = nfsa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: tb/next_fit_slot_allocator_tb.sv
`timescale 1ns / 100ps

module next_fit_slot_allocator_tb;

    // One request word as the sender sees it.
    typedef struct packed
    {
        nfsa_pkg::op_t op;
        logic [7:0]    slot;
    } request_t;

    // One result word as the receiver should see it.
    typedef struct packed
    {
        nfsa_pkg::status_t status;
        logic [7:0]        granted;
        logic [7:0]        count;
    } outcome_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input has a known value at time 0.
    // ------------------------------------------------------------------
    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic       op           = nfsa_pkg::OP_ALLOC;
    logic [7:0] slot_to_free = 8'd0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [1:0] status;
    logic [7:0] granted_slot;
    logic [7:0] used_count;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    next_fit_slot_allocator dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .slot_to_free (slot_to_free),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .granted_slot (granted_slot),
        .used_count   (used_count)
    );

    // ------------------------------------------------------------------
    // Shadow of the pool: used flags, count of used slots and the slot
    // the next-fit search starts from. Advanced once per accepted word.
    // ------------------------------------------------------------------
    bit slot_taken [nfsa_pkg::SLOTS];
    int slots_held   = 0;
    int next_fit_pos = 0;

    request_t pending_words [$];   // words waiting for the driver
    outcome_t expected_results [$]; // predictions waiting for the DUT

    bit quiet        = 1'b0;  // last phase: no idling on either side
    bit in_taken     = 1'b0;  // word on the input was taken at last posedge
    int in_gap       = 0;
    int out_gap      = 0;
    int error_count  = 0;

    // coverage tallies for the summary
    int n_requests   = 0;
    int n_grants     = 0;
    int n_full       = 0;
    int n_freed      = 0;
    int n_idle_free  = 0;
    int n_zero_free  = 0;
    int peak_held    = 0;
    int top_grant    = 0;

    // Apply one request to the shadow pool and return the result word.
    function automatic outcome_t allocate_or_release(request_t r);
        outcome_t res;
        int       id;
        res.status  = nfsa_pkg::ST_DONE;
        res.granted = 8'd0;
        if (r.op == nfsa_pkg::OP_ALLOC)
        begin
            // circular scan starting at the last grant itself; slot 0 skipped
            res.status = nfsa_pkg::ST_FULL;
            for (int k = 0; k < nfsa_pkg::SLOTS && res.status == nfsa_pkg::ST_FULL;
                 k++)
            begin
                id = (next_fit_pos + k) % nfsa_pkg::SLOTS;
                if (id != 0 && !slot_taken[id])
                begin
                    slot_taken[id] = 1'b1;
                    slots_held++;
                    next_fit_pos = id;
                    res.status   = nfsa_pkg::ST_DONE;
                    res.granted  = id[7:0];
                end
            end
        end
        else if (r.slot == 8'd0)
            res.status = nfsa_pkg::ST_ZERO;
        else if (r.slot >= nfsa_pkg::SLOTS || !slot_taken[r.slot])
            res.status = nfsa_pkg::ST_NOT_IN_USE;   // flag and count stay as they are
        else
        begin
            slot_taken[r.slot] = 1'b0;
            if (slots_held > 0)
                slots_held--;
        end
        res.count = slots_held[7:0];
        return res;
    endfunction

    // Random slot that the shadow pool holds right now (random if none).
    function automatic logic [7:0] pick_held_slot();
        int nth;
        if (slots_held == 0)
            return 8'($urandom_range(1, 255));
        nth = $urandom_range(0, slots_held - 1);
        for (int id = 1; id < nfsa_pkg::SLOTS; id++)
        begin
            if (slot_taken[id])
            begin
                if (nth == 0)
                    return id[7:0];
                nth--;
            end
        end
        return 8'd0;
    endfunction

    task automatic queue_word(nfsa_pkg::op_t o, logic [7:0] s);
        request_t r;
        r.op   = o;
        r.slot = s;
        pending_words.push_back(r);
    endtask

    // Random traffic; alloc_pct sets the allocate share. Frees mostly hit
    // held slots so the pool really fills and drains; the rest is noise.
    // The queue is refilled lazily so the chosen slots track the pool.
    task automatic queue_random(int count, int alloc_pct);
        int roll;
        for (int i = 0; i < count; i++)
        begin
            while (pending_words.size() >= 4)
                @(negedge clk);
            roll = $urandom_range(0, 99);
            if (roll < alloc_pct)
                queue_word(nfsa_pkg::OP_ALLOC, 8'($urandom));
            else
            begin
                roll = $urandom_range(0, 9);
                if (roll < 8)
                    queue_word(nfsa_pkg::OP_FREE, pick_held_slot());
                else if (roll == 8)
                    queue_word(nfsa_pkg::OP_FREE, 8'($urandom));
                else
                    queue_word(nfsa_pkg::OP_FREE, 8'd0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: presents words at the falling edge. A word stays on the bus
    // until taken; between words it may insert a random idle burst.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        request_t w;
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() == 0)
                in_valid <= 1'b0;
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                in_gap = $urandom_range(0, 9);
                in_valid <= 1'b0;
            end
            else
            begin
                w = pending_words.pop_front();
                in_valid     <= 1'b1;
                op           <= w.op;
                slot_to_free <= w.slot;
            end
        end
    end

    // Receiver back-pressure: random stall bursts, none in the last phase.
    always @(negedge clk)
    begin
        if (out_gap > 0)
        begin
            out_gap--;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 6) == 0)
        begin
            out_gap = $urandom_range(0, 9);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Monitor: at the rising edge, predict for each taken request word and
    // check each taken result word against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        request_t req;
        outcome_t want;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                req.op   = nfsa_pkg::op_t'(op);
                req.slot = slot_to_free;
                expected_results.push_back(allocate_or_release(req));
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with no request outstanding: %0d %0d %0d",
                           status, granted_slot, used_count);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    n_requests++;
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        error_count++;
                    end
                    if (granted_slot !== want.granted)
                    begin
                        $error("granted_slot: expected %0d, got %0d",
                               want.granted, granted_slot);
                        error_count++;
                    end
                    if (used_count !== want.count)
                    begin
                        $error("used_count: expected %0d, got %0d",
                               want.count, used_count);
                        error_count++;
                    end
                    case (want.status)
                        nfsa_pkg::ST_FULL:       n_full++;
                        nfsa_pkg::ST_NOT_IN_USE: n_idle_free++;
                        nfsa_pkg::ST_ZERO:       n_zero_free++;
                        default:
                        begin
                            if (want.granted != 8'd0)
                                n_grants++;
                            else
                                n_freed++;
                        end
                    endcase
                    if (int'(want.count) > peak_held)
                        peak_held = int'(want.count);
                    if (int'(want.granted) > top_grant)
                        top_grant = int'(want.granted);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: slot zero, frees of idle slots, next-fit skipping a
        // freed slot behind the search point, drain to empty, bit patterns.
        queue_word(nfsa_pkg::OP_FREE,  8'd0);     // ignored slot zero
        queue_word(nfsa_pkg::OP_FREE,  8'd255);   // top slot, not in use
        queue_word(nfsa_pkg::OP_FREE,  8'd1);
        queue_word(nfsa_pkg::OP_ALLOC, 8'hFF);    // slot field ignored -> slot 1
        queue_word(nfsa_pkg::OP_ALLOC, 8'h00);    // -> 2
        queue_word(nfsa_pkg::OP_ALLOC, 8'hAA);    // -> 3
        queue_word(nfsa_pkg::OP_FREE,  8'd2);
        queue_word(nfsa_pkg::OP_FREE,  8'd2);     // double free
        queue_word(nfsa_pkg::OP_ALLOC, 8'h55);    // next fit: 4, not the hole at 2
        queue_word(nfsa_pkg::OP_FREE,  8'd1);
        queue_word(nfsa_pkg::OP_FREE,  8'd3);
        queue_word(nfsa_pkg::OP_FREE,  8'd4);     // pool empty again
        queue_word(nfsa_pkg::OP_ALLOC, 8'd0);     // search starts at 4 itself -> 4
        queue_word(nfsa_pkg::OP_FREE,  8'd5);     // not in use
        queue_word(nfsa_pkg::OP_FREE,  8'h80);
        queue_word(nfsa_pkg::OP_FREE,  8'h7F);
        queue_word(nfsa_pkg::OP_FREE,  8'hAA);
        queue_word(nfsa_pkg::OP_FREE,  8'h55);
        queue_word(nfsa_pkg::OP_ALLOC, 8'h01);
        queue_word(nfsa_pkg::OP_FREE,  8'd0);

        // Fill past capacity (search wraps, pool-full hits), churn while
        // nearly full, drain, then a mixed tail with no idling.
        queue_random(280, 97);
        queue_random(40, 60);
        queue_random(130, 10);
        quiet = 1'b1;
        queue_random(50, 50);

        do
            @(posedge clk);
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
        // a late or extra result would show up within a full scan
        repeat (nfsa_pkg::SLOTS + 8) @(posedge clk);

        $display("Checked %0d results: %0d grants, %0d pool-full, %0d frees,",
                 n_requests, n_grants, n_full, n_freed);
        $display("%0d frees of idle slots, %0d slot-zero frees; peak in use %0d, top slot %0d.",
                 n_idle_free, n_zero_free, peak_held, top_grant);
        if (error_count == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog, far above the slowest legal run (520 words of full scans
    // plus stalls and gaps, and the clearing pass after reset).
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/nfsa_pkg.sv
hw/rtl/next_fit_slot_allocator.sv
tb/next_fit_slot_allocator_tb.sv
